>>> hdl/btenv_pkg.sv
// Package with the types, constants and helpers of the bipolar triangle envelope driver.
package btenv_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_START    = 2'd1,
    OP_STOP     = 2'd2,
    OP_SET_GEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DUTY_KEEP,
    DUTY_ZERO,
    DUTY_CALC
  } duty_op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] gear_level;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_compare;
    logic        upper_enable;
    logic        lower_enable;
    logic        master_enable;
    logic        modulation_on;
    logic        running;
  } out_t;

  // Enable vector bit positions.
  localparam int EN_UPPER  = 0;
  localparam int EN_LOWER  = 1;
  localparam int EN_MASTER = 2;
  localparam int EN_MOD    = 3;

  localparam logic [6:0]  GEAR_MAX     = 7'd100;
  localparam logic [6:0]  GEAR_DEFAULT = 7'd50;
  localparam logic [6:0]  PEAK_BASE    = 7'd10;
  localparam logic [15:0] PERIOD_RESET = 16'd3000;

  // Exact reciprocal of 250 for dividends below 2**23.
  localparam logic [23:0] DIV_RECIP = 24'd8589935;
  localparam int          DIV_SHIFT = 31;

  typedef struct packed {
    duty_op_t    duty_op;
    logic [6:0]  index;
    logic [15:0] period;
    logic [3:0]  enables;
    logic        active;
  } item_t;

  typedef struct packed {
    duty_op_t    duty_op;
    logic [22:0] product;
    logic [3:0]  enables;
    logic        active;
  } prod_t;

  function automatic logic [6:0] clamp_gear(input logic [7:0] g);
    logic [6:0] res;
    if (g > {1'b0, GEAR_MAX}) begin
      res = GEAR_MAX;
    end else begin
      res = g[6:0];
    end
    return res;
  endfunction

endpackage

>>> hdl/btenv_ctrl.sv
// Event decoder and ramp state machine; issues one duty work item per accepted beat.
module btenv_ctrl
  import btenv_pkg::*;
#(
  parameter int PERIOD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        item_valid,
  input  logic        item_ready,
  output item_t       item
);

  localparam logic [15:0] PERIOD_MASK = (PERIOD_WIDTH >= 16) ? 16'hFFFF :
                                        16'((32'd1 << PERIOD_WIDTH) - 32'd1);

  logic [15:0] period_r;
  logic        active_r, active_nxt;
  logic [6:0]  gear_r, gear_nxt;
  logic [6:0]  peak_r, peak_nxt;
  logic [6:0]  rise_r, rise_nxt;
  logic [6:0]  fall_r, fall_nxt;
  logic        desc_r, desc_nxt;
  logic        upper_sel_r, upper_sel_nxt;
  logic [3:0]  en_r, en_nxt;
  logic        valid_r;
  item_t       item_r, item_nxt;
  logic        accept;

  assign in_ready   = !valid_r || item_ready;
  assign accept     = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    logic [6:0] g;
    logic [6:0] fall;
    logic       desc;
    active_nxt    = active_r;
    gear_nxt      = gear_r;
    peak_nxt      = peak_r;
    rise_nxt      = rise_r;
    fall_nxt      = fall_r;
    desc_nxt      = desc_r;
    upper_sel_nxt = upper_sel_r;
    en_nxt        = en_r;
    item_nxt.duty_op = DUTY_KEEP;
    item_nxt.index   = 7'd0;
    g    = 7'd0;
    fall = fall_r;
    desc = desc_r;
    unique case (in_data.operation)
      OP_TICK: begin
        if (active_r) begin
          if (gear_r == 7'd0) begin
            item_nxt.duty_op = DUTY_ZERO;
          end else begin
            en_nxt[EN_UPPER]  = upper_sel_r;
            en_nxt[EN_LOWER]  = !upper_sel_r;
            en_nxt[EN_MASTER] = 1'b1;
            if (!desc) begin
              if (rise_r < peak_r) begin
                item_nxt.duty_op = DUTY_CALC;
                item_nxt.index   = rise_r;
                rise_nxt         = rise_r + 7'd1;
              end else begin
                fall = rise_r;
                desc = 1'b1;
              end
            end
            if (desc) begin
              if (fall != 7'd0) begin
                fall             = fall - 7'd1;
                item_nxt.duty_op = DUTY_CALC;
                item_nxt.index   = fall;
              end
              if (fall == 7'd0) begin
                rise_nxt      = 7'd0;
                desc          = 1'b0;
                upper_sel_nxt = !upper_sel_r;
              end
            end
            fall_nxt = fall;
            desc_nxt = desc;
          end
        end
      end
      OP_START: begin
        g = (in_data.gear_level != 8'd0) ? clamp_gear(in_data.gear_level) : gear_r;
        if (g == 7'd0) begin
          g = GEAR_DEFAULT;
        end
        gear_nxt      = g;
        rise_nxt      = 7'd0;
        fall_nxt      = 7'd0;
        desc_nxt      = 1'b0;
        peak_nxt      = PEAK_BASE + g;
        upper_sel_nxt = 1'b1;
        en_nxt        = 4'd0;
        en_nxt[EN_UPPER]  = 1'b1;
        en_nxt[EN_MASTER] = 1'b1;
        en_nxt[EN_MOD]    = 1'b1;
        item_nxt.duty_op  = DUTY_ZERO;
        active_nxt        = 1'b1;
      end
      OP_STOP: begin
        active_nxt       = 1'b0;
        upper_sel_nxt    = 1'b1;
        rise_nxt         = 7'd0;
        fall_nxt         = 7'd0;
        desc_nxt         = 1'b0;
        peak_nxt         = 7'd0;
        en_nxt           = 4'd0;
        item_nxt.duty_op = DUTY_ZERO;
      end
      OP_SET_GEAR: begin
        g        = clamp_gear(in_data.gear_level);
        gear_nxt = g;
        if (active_r) begin
          peak_nxt = PEAK_BASE + g;
        end
      end
      default: begin
      end
    endcase
    item_nxt.period  = period_r & PERIOD_MASK;
    item_nxt.enables = en_nxt;
    item_nxt.active  = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      active_r    <= 1'b0;
      gear_r      <= 7'd0;
      peak_r      <= 7'd0;
      rise_r      <= 7'd0;
      fall_r      <= 7'd0;
      desc_r      <= 1'b0;
      upper_sel_r <= 1'b1;
      en_r        <= 4'd0;
      valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (accept) begin
        active_r    <= active_nxt;
        gear_r      <= gear_nxt;
        peak_r      <= peak_nxt;
        rise_r      <= rise_nxt;
        fall_r      <= fall_nxt;
        desc_r      <= desc_nxt;
        upper_sel_r <= upper_sel_nxt;
        en_r        <= en_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> hdl/btenv_duty.sv
// Two-stage duty pipeline: period times index, then division by 250 into the result register.
module btenv_duty
  import btenv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic        prod_valid_r;
  prod_t       prod_r;
  logic        prod_ready;
  logic        res_valid_r;
  out_t        res_r;
  logic        res_ready;
  logic [46:0] scaled;
  logic [15:0] quotient;

  assign res_ready  = !res_valid_r || out_ready;
  assign prod_ready = !prod_valid_r || res_ready;
  assign item_ready = prod_ready;
  assign out_valid  = res_valid_r;
  assign out_data   = res_r;

  assign scaled   = 47'(prod_r.product) * 47'(DIV_RECIP);
  assign quotient = scaled[DIV_SHIFT +: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (prod_ready) begin
      prod_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && item_valid) begin
      prod_r.duty_op <= item.duty_op;
      prod_r.product <= 23'(item.period) * 23'(item.index);
      prod_r.enables <= item.enables;
      prod_r.active  <= item.active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      res_r       <= '0;
    end else if (res_ready) begin
      res_valid_r <= prod_valid_r;
      if (prod_valid_r) begin
        unique case (prod_r.duty_op)
          DUTY_CALC: res_r.duty_compare <= quotient;
          DUTY_ZERO: res_r.duty_compare <= 16'd0;
          default:   res_r.duty_compare <= res_r.duty_compare;
        endcase
        res_r.upper_enable  <= prod_r.enables[EN_UPPER];
        res_r.lower_enable  <= prod_r.enables[EN_LOWER];
        res_r.master_enable <= prod_r.enables[EN_MASTER];
        res_r.modulation_on <= prod_r.enables[EN_MOD];
        res_r.running       <= prod_r.active;
      end
    end
  end

endmodule

>>> hdl/bipolar_triangle_envelope_driver.sv
// Top level of the bipolar triangle envelope driver.
// Every accepted event beat (tick, start, stop or set gear) yields exactly one result beat,
// and a new event can be taken in every cycle while the output is not stalled. The path is the
// event stage that updates the ramp state followed by the two registered stages of the duty
// path, one for the period-times-index product and one for the division by 250 done as a
// multiply by an exact reciprocal. Each stage holds its beat under backpressure and bubbles
// close up, so input is refused only when all three stages are full and the output is stalled.
// The period register resets to 3000 and only its low PERIOD_WIDTH bits scale the compare
// value; it is meant to be written between events.
module bipolar_triangle_envelope_driver
  import btenv_pkg::*;
#(
  parameter int PERIOD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  btenv_ctrl #(
    .PERIOD_WIDTH(PERIOD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item)
  );

  btenv_duty u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/bipolar_triangle_envelope_driver_test.sv
// Self-checking testbench for the bipolar triangle envelope driver.
`timescale 1ns / 1ps

module bipolar_triangle_envelope_driver_test
  import btenv_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PRINT_CAP = 40;

  class envelope_tracker;
    logic [15:0] period;
    bit          active;
    bit          descending;
    bit          upper_sel;
    logic [6:0]  gear;
    logic [6:0]  peak;
    logic [6:0]  rise;
    logic [6:0]  fall;
    logic [15:0] compare;
    logic [3:0]  enables;
    out_t        due_envelopes[$];
    int          errors;

    function new();
      period     = PERIOD_RESET;
      active     = 1'b0;
      descending = 1'b0;
      upper_sel  = 1'b1;
      gear       = '0;
      peak       = '0;
      rise       = '0;
      fall       = '0;
      compare    = '0;
      enables    = '0;
      errors     = 0;
    endfunction

    function int pending();
      return due_envelopes.size();
    endfunction

    function logic [15:0] scaled_duty(logic [6:0] idx);
      logic [31:0] product;
      product = 32'(period) * 32'(idx);
      return 16'(product / 32'd250);
    endfunction

    function void note_event(in_t ev);
      logic [6:0] g;
      out_t       res;
      g = (ev.gear_level > 8'd100) ? GEAR_MAX : ev.gear_level[6:0];
      case (ev.operation)
        OP_TICK: begin
          if (active && gear == 7'd0) begin
            compare = '0;
          end else if (active) begin
            enables[EN_UPPER]  = upper_sel;
            enables[EN_LOWER]  = !upper_sel;
            enables[EN_MASTER] = 1'b1;
            if (!descending) begin
              if (rise < peak) begin
                compare = scaled_duty(rise);
                rise = rise + 7'd1;
              end else begin
                fall = rise;
                descending = 1'b1;
              end
            end
            if (descending) begin
              if (fall > 7'd0) begin
                fall = fall - 7'd1;
                compare = scaled_duty(fall);
              end
              if (fall == 7'd0) begin
                rise = '0;
                descending = 1'b0;
                upper_sel = !upper_sel;
              end
            end
          end
        end
        OP_START: begin
          if (ev.gear_level != 8'd0) gear = g;
          if (gear == 7'd0) gear = GEAR_DEFAULT;
          rise = '0;
          fall = '0;
          descending = 1'b0;
          peak = PEAK_BASE + gear;
          upper_sel = 1'b1;
          enables = '0;
          enables[EN_UPPER] = 1'b1;
          enables[EN_MASTER] = 1'b1;
          enables[EN_MOD] = 1'b1;
          compare = scaled_duty(7'd0);
          active = 1'b1;
        end
        OP_STOP: begin
          active = 1'b0;
          upper_sel = 1'b1;
          rise = '0;
          fall = '0;
          descending = 1'b0;
          peak = '0;
          compare = '0;
          enables = '0;
        end
        default: begin
          gear = g;
          if (active) peak = PEAK_BASE + gear;
        end
      endcase
      res.duty_compare  = compare;
      res.upper_enable  = enables[EN_UPPER];
      res.lower_enable  = enables[EN_LOWER];
      res.master_enable = enables[EN_MASTER];
      res.modulation_on = enables[EN_MOD];
      res.running       = active;
      due_envelopes.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH: %s", what);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_envelope(out_t got);
      out_t want;
      if (due_envelopes.size() == 0) begin
        report("result beat with no event outstanding");
      end else begin
        want = due_envelopes.pop_front();
        check_field("duty_compare", got.duty_compare, want.duty_compare);
        check_field("upper_enable", got.upper_enable, want.upper_enable);
        check_field("lower_enable", got.lower_enable, want.lower_enable);
        check_field("master_enable", got.master_enable, want.master_enable);
        check_field("modulation_on", got.modulation_on, want.modulation_on);
        check_field("running", got.running, want.running);
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;

  envelope_tracker sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  bipolar_triangle_envelope_driver #(
    .PERIOD_WIDTH(16)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_envelope(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bipolar_triangle_envelope_driver regression: fail");
      $finish;
    end
  end

  task automatic send_event(in_t ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    sb.note_event(ev);
  endtask

  task automatic send_op(op_t op, logic [7:0] g);
    in_t ev;
    ev.operation  = op;
    ev.gear_level = g;
    send_event(ev);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_period(logic [15:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.period = value;
  endtask

  function automatic logic [7:0] pick_gear();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 8'($urandom_range(1, 12));
    if (roll < 80) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic directed_events();
    send_op(OP_TICK, 8'd0);
    send_op(OP_SET_GEAR, 8'd0);
    send_op(OP_START, 8'd0);
    send_op(OP_TICK, 8'd255);
    send_op(OP_TICK, 8'd0);
    send_op(OP_STOP, 8'd0);
    send_op(OP_TICK, 8'd0);
    send_op(OP_START, 8'd255);
    send_op(OP_TICK, 8'd0);
    send_op(OP_SET_GEAR, 8'd101);
    send_op(OP_SET_GEAR, 8'd128);
    send_op(OP_TICK, 8'd0);
    send_op(OP_SET_GEAR, 8'd0);
    send_op(OP_TICK, 8'd0);
    send_op(OP_START, 8'd0);
    send_op(OP_SET_GEAR, 8'd100);
    send_op(OP_TICK, 8'd0);
    send_op(OP_START, 8'd1);
    send_op(OP_TICK, 8'd0);
    send_op(OP_STOP, 8'd0);
    send_op(OP_STOP, 8'd255);
    send_op(OP_SET_GEAR, 8'd255);
    send_op(OP_START, 8'd127);
    send_op(OP_TICK, 8'd0);
    send_op(OP_STOP, 8'd0);
  endtask

  task automatic random_events(int target);
    int   count;
    in_t  ev;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 99) < 80) begin
        send_op(OP_START, pick_gear());
        count++;
        repeat ($urandom_range(10, 70)) begin
          if ($urandom_range(0, 99) < 6) send_op(OP_SET_GEAR, pick_gear());
          else send_op(OP_TICK, 8'($urandom_range(0, 255)));
          count++;
        end
        if ($urandom_range(0, 1) == 1) begin
          send_op(OP_STOP, 8'($urandom_range(0, 255)));
          count++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          ev.operation  = op_t'($urandom_range(0, 3));
          ev.gear_level = 8'($urandom_range(0, 255));
          if (ev.operation != OP_TICK || sb.active) count++;
          send_event(ev);
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 16;
        recv_idle_pct <= 45;
      end else if (phase < 4) begin
        send_idle_pct = 45;
        recv_idle_pct <= 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      case (phase)
        1: write_period(16'hFFFF);
        2: write_period(16'd0);
        3: write_period(16'd1);
        4: write_period(16'($urandom_range(0, 65535)));
        5: write_period(16'd250);
        default: ;
      endcase
      if (phase == 0) directed_events();
      if (phase == 4) hold_requests <= hold_requests + 1;
      random_events(42);
      if (phase == 1) wait_drained();
      random_events(42);
      wait_drained();
    end
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("bipolar_triangle_envelope_driver regression: pass");
    end else begin
      $display("bipolar_triangle_envelope_driver regression: fail");
    end
    $finish;
  end

endmodule
